### rtl/core/mdbr_pkg.sv
// Package for the MDB response receiver: shared types, codes and constants.
// Used by every module of the receiver and by its checker.
package mdbr_pkg;

    localparam int MAX_FRAME = 36;
    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    localparam int NUM_SLOTS = 10;
    localparam int ID_VER_POS = 28;

    localparam logic [7:0] ACK_BYTE = 8'h00;
    localparam logic [15:0] CURRENCY_A = 16'h0643;
    localparam logic [15:0] CURRENCY_B = 16'h0810;
    localparam logic [7:0] RESP_TIME_RESET = 8'hFF;

    localparam logic [2:0] CMD_RESET = 3'd0;
    localparam logic [2:0] CMD_VEND = 3'd3;

    localparam logic [7:0] SUB_VEND_REQUEST = 8'd0;
    localparam logic [7:0] SUB_VEND_CANCEL = 8'd1;
    localparam logic [7:0] SUB_VEND_SUCCESS = 8'd2;
    localparam logic [7:0] SUB_NEG_VEND = 8'd6;

    localparam logic [7:0] HDR_JUST_RESET = 8'h00;
    localparam logic [7:0] HDR_CONFIG = 8'h01;
    localparam logic [7:0] HDR_BEGIN_SESSION = 8'h03;
    localparam logic [7:0] HDR_SESS_CANCEL = 8'h04;
    localparam logic [7:0] HDR_VEND_APPROVED = 8'h05;
    localparam logic [7:0] HDR_VEND_DENIED = 8'h06;
    localparam logic [7:0] HDR_END_SESSION = 8'h07;
    localparam logic [7:0] HDR_PERIPH_ID = 8'h09;
    localparam logic [7:0] HDR_OUT_OF_SEQ = 8'h0B;
    localparam logic [7:0] HDR_REVAL_APPROVED = 8'h0D;
    localparam logic [7:0] HDR_REVAL_DENIED = 8'h0E;

    localparam int SLOT_HDR = 0;
    localparam int SLOT_LEVEL = 1;
    localparam int SLOT_CC_HI = 2;
    localparam int SLOT_CC_LO = 3;
    localparam int SLOT_SCALE = 4;
    localparam int SLOT_DECIMALS = 5;
    localparam int SLOT_RESP_TIME = 6;
    localparam int SLOT_MISC = 7;
    localparam int SLOT_VER_HI = 8;
    localparam int SLOT_VER_LO = 9;

    typedef enum logic [3:0] {
        RES_IN_PROGRESS = 4'd0,
        RES_ACK = 4'd1,
        RES_NACK = 4'd2,
        RES_REPEAT = 4'd3,
        RES_JUST_RESET = 4'd4,
        RES_CONFIG = 4'd5,
        RES_CURRENCY_ERR = 4'd6,
        RES_OK_DATA = 4'd7,
        RES_BEGIN_SESSION = 4'd8,
        RES_SESS_CANCEL = 4'd9,
        RES_VEND_APPROVED = 4'd10,
        RES_VEND_DENIED = 4'd11,
        RES_END_SESSION = 4'd12,
        RES_PERIPH_ID = 4'd13,
        RES_REVAL_APPROVED = 4'd14,
        RES_REVAL_DENIED = 4'd15
    } result_code_t;

    typedef enum logic [2:0] {
        ST_INACTIVE = 3'd0,
        ST_DISABLED = 3'd1,
        ST_ENABLED = 3'd2,
        ST_SESSION_IDLE = 3'd3,
        ST_VEND = 3'd4,
        ST_REVALUE = 3'd5,
        ST_NEG_VEND = 3'd6
    } session_state_t;

    typedef struct packed {
        logic [8:0] bus_char;
        logic [2:0] sent_command;
        logic [7:0] sent_subcommand;
    } item_t;

    typedef struct packed {
        logic frame_end;
        logic single_char;
        logic sum_ok;
        logic [7:0] last_byte;
        logic [NUM_SLOTS-1:0][7:0] bytes;
    } frame_info_t;

    typedef struct packed {
        result_code_t result_code;
        session_state_t machine_state;
        logic [7:0] max_response_time;
        logic [15:0] currency_code;
        logic [7:0] reader_level;
        logic [7:0] price_scale;
        logic [7:0] decimal_digits;
        logic [7:0] misc_options;
        logic [15:0] software_version;
    } result_t;

    // Frame position of each captured byte: header and config bytes first, then
    // the two software version bytes of the peripheral ID frame.
    function automatic logic [CNT_W-1:0] slot_pos(input int slot);
        int pos;
        begin
            if (slot < SLOT_VER_HI)
            begin
                pos = slot;
            end
            else
            begin
                pos = ID_VER_POS + slot - SLOT_VER_HI;
            end
            return CNT_W'(pos);
        end
    endfunction

endpackage

### rtl/core/mdbr_input_stage.sv
// Input register of the MDB response receiver: holds one item until it is processed.
// Depends on mdbr_pkg.
module mdbr_input_stage import mdbr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic [8:0] bus_char,
    input  logic [2:0] sent_command,
    input  logic [7:0] sent_subcommand,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_stall = valid_reg && !advance;
    assign load = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{bus_char: bus_char, sent_command: sent_command,
                          sent_subcommand: sent_subcommand};
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

### rtl/core/mdbr_frame_tracker.sv
// Frame tracker: character count, running checksum and capture of the frame bytes
// that the decoder reads. Depends on mdbr_pkg.
module mdbr_frame_tracker import mdbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [8:0]  bus_char,
    output frame_info_t info
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       cap_reg [NUM_SLOTS];
    logic             overflow;
    logic             mode;
    logic [7:0]       data;

    assign mode = bus_char[8];
    assign data = bus_char[7:0];
    assign overflow = count_reg >= CNT_W'(MAX_FRAME);

    always_comb
    begin
        count_next = count_reg;
        sum_next = sum_reg;
        if (step)
        begin
            if (overflow || mode)
            begin
                count_next = '0;
                sum_next = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next = sum_reg + data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (step && !overflow && count_reg == slot_pos(k))
            begin
                cap_reg[k] <= data;
            end
        end
    end

    // A byte at or past the frame length reads as zero; the closing character
    // itself is taken straight from the current item.
    always_comb
    begin
        info.frame_end = !overflow && mode;
        info.single_char = count_reg == '0;
        info.sum_ok = sum_reg == data;
        info.last_byte = data;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (slot_pos(k) < count_reg)
            begin
                info.bytes[k] = cap_reg[k];
            end
            else if (slot_pos(k) == count_reg)
            begin
                info.bytes[k] = data;
            end
            else
            begin
                info.bytes[k] = '0;
            end
        end
    end

endmodule

### rtl/core/mdbr_decoder.sv
// Response decoder: turns a closed frame into a result code and keeps the session
// state and the captured config and ID registers. Depends on mdbr_pkg.
module mdbr_decoder import mdbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  frame_info_t info,
    input  logic [2:0]  sent_command,
    input  logic [7:0]  sent_subcommand,
    output result_t     result
);

    result_t     state_reg;
    result_t     state_next;
    logic [15:0] cc;

    assign cc = {info.bytes[SLOT_CC_HI], info.bytes[SLOT_CC_LO]};

    always_comb
    begin
        state_next = state_reg;
        state_next.result_code = RES_IN_PROGRESS;
        if (info.frame_end)
        begin
            if (info.single_char)
            begin
                if (info.last_byte == ACK_BYTE)
                begin
                    state_next.result_code = RES_ACK;
                    if (sent_command == CMD_VEND)
                    begin
                        unique case (sent_subcommand)
                            SUB_VEND_REQUEST: state_next.machine_state = ST_VEND;
                            SUB_VEND_CANCEL, SUB_VEND_SUCCESS:
                                state_next.machine_state = ST_SESSION_IDLE;
                            SUB_NEG_VEND: state_next.machine_state = ST_NEG_VEND;
                            default: state_next.machine_state = state_reg.machine_state;
                        endcase
                    end
                    else if (sent_command == CMD_RESET)
                    begin
                        state_next.machine_state = ST_INACTIVE;
                    end
                end
                else
                begin
                    state_next.result_code = RES_NACK;
                end
            end
            else if (!info.sum_ok)
            begin
                state_next.result_code = RES_REPEAT;
            end
            else
            begin
                unique case (info.bytes[SLOT_HDR])
                    HDR_JUST_RESET:
                    begin
                        state_next.machine_state = ST_INACTIVE;
                        state_next.result_code = RES_JUST_RESET;
                    end
                    HDR_CONFIG:
                    begin
                        state_next.machine_state = ST_DISABLED;
                        state_next.currency_code = cc;
                        if (cc == CURRENCY_A || cc == CURRENCY_B)
                        begin
                            state_next.reader_level = info.bytes[SLOT_LEVEL];
                            state_next.price_scale = info.bytes[SLOT_SCALE];
                            state_next.decimal_digits = info.bytes[SLOT_DECIMALS];
                            state_next.max_response_time = info.bytes[SLOT_RESP_TIME];
                            state_next.misc_options = info.bytes[SLOT_MISC];
                            state_next.result_code = RES_CONFIG;
                        end
                        else
                        begin
                            state_next.result_code = RES_CURRENCY_ERR;
                        end
                    end
                    HDR_BEGIN_SESSION:
                    begin
                        state_next.machine_state = ST_SESSION_IDLE;
                        state_next.result_code = RES_BEGIN_SESSION;
                    end
                    HDR_SESS_CANCEL: state_next.result_code = RES_SESS_CANCEL;
                    HDR_VEND_APPROVED: state_next.result_code = RES_VEND_APPROVED;
                    HDR_VEND_DENIED:
                    begin
                        state_next.machine_state = ST_SESSION_IDLE;
                        state_next.result_code = RES_VEND_DENIED;
                    end
                    HDR_END_SESSION:
                    begin
                        state_next.machine_state = ST_ENABLED;
                        state_next.result_code = RES_END_SESSION;
                    end
                    HDR_PERIPH_ID:
                    begin
                        state_next.software_version = {info.bytes[SLOT_VER_HI],
                                                       info.bytes[SLOT_VER_LO]};
                        state_next.result_code = RES_PERIPH_ID;
                    end
                    HDR_OUT_OF_SEQ:
                    begin
                        state_next.machine_state = ST_SESSION_IDLE;
                        state_next.result_code = RES_OK_DATA;
                    end
                    HDR_REVAL_APPROVED: state_next.result_code = RES_REVAL_APPROVED;
                    HDR_REVAL_DENIED: state_next.result_code = RES_REVAL_DENIED;
                    default: state_next.result_code = RES_OK_DATA;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.result_code <= RES_IN_PROGRESS;
            state_reg.machine_state <= ST_INACTIVE;
            state_reg.max_response_time <= RESP_TIME_RESET;
            state_reg.currency_code <= '0;
            state_reg.reader_level <= '0;
            state_reg.price_scale <= '0;
            state_reg.decimal_digits <= '0;
            state_reg.misc_options <= '0;
            state_reg.software_version <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    assign result = state_next;

endmodule

### rtl/core/mdb_response_receiver.sv
// Top level of the MDB response receiver: input register, frame tracker, decoder and
// result register. Depends on mdbr_pkg and the mdbr_* modules.
//
// Each 9-bit bus character is one item and yields one result item: in progress until
// a character with the mode bit closes the frame, then the decoded response together
// with the current session state and captured config and ID fields. The result item
// passes through the input register and then the result register, and one item is
// accepted every cycle while the result side takes them; the running checksum and
// per-position byte capture keep the whole frame decode within the single step of
// the closing character.
module mdb_response_receiver import mdbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [8:0]  bus_char,
    input  logic [2:0]  sent_command,
    input  logic [7:0]  sent_subcommand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  result_code,
    output logic [2:0]  machine_state,
    output logic [7:0]  max_response_time,
    output logic [15:0] currency_code,
    output logic [7:0]  reader_level,
    output logic [7:0]  price_scale,
    output logic [7:0]  decimal_digits,
    output logic [7:0]  misc_options,
    output logic [15:0] software_version
);

    logic        item_valid;
    item_t       item;
    logic        advance;
    logic        step;
    frame_info_t info;
    result_t     result;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;

    assign advance = !out_valid_reg || !out_stall;
    assign step = item_valid && advance;

    mdbr_input_stage u_input
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .bus_char        (bus_char),
        .sent_command    (sent_command),
        .sent_subcommand (sent_subcommand),
        .advance         (advance),
        .item_valid      (item_valid),
        .item            (item)
    );

    mdbr_frame_tracker u_frame
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .bus_char (item.bus_char),
        .info     (info)
    );

    mdbr_decoder u_decode
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .info            (info),
        .sent_command    (item.sent_command),
        .sent_subcommand (item.sent_subcommand),
        .result          (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_code = out_reg.result_code;
    assign machine_state = out_reg.machine_state;
    assign max_response_time = out_reg.max_response_time;
    assign currency_code = out_reg.currency_code;
    assign reader_level = out_reg.reader_level;
    assign price_scale = out_reg.price_scale;
    assign decimal_digits = out_reg.decimal_digits;
    assign misc_options = out_reg.misc_options;
    assign software_version = out_reg.software_version;

endmodule

### rtl/core/mdbr_checker.sv
// Port-level checker for the MDB response receiver, bound to the top level.
// Depends on mdbr_pkg.
module mdbr_checker import mdbr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  result_code,
    input logic [2:0]  machine_state,
    input logic [15:0] currency_code
);

    // A held result item keeps its valid and its code.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_code))
        else $error("stalled result item changed");

    // The input side only waits when a result item is waiting too.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result item");

    a_config_currency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code == RES_CONFIG |->
            currency_code == CURRENCY_A || currency_code == CURRENCY_B)
        else $error("config accepted with unknown currency");

    a_currency_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code == RES_CURRENCY_ERR |-> machine_state == ST_DISABLED)
        else $error("currency error without disabled state");

    a_session_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_code == RES_BEGIN_SESSION || result_code == RES_VEND_DENIED)
            |-> machine_state == ST_SESSION_IDLE)
        else $error("session start or vend denial without session idle state");

endmodule

bind mdb_response_receiver mdbr_checker u_checker (.*);
